FILE: sv/dqbt_pkg.sv
// Shared types, constants and helper functions of the dual quaternion bone transform.
package dqbt_pkg;

  localparam logic [3:0] ROOT_MARK = 4'hF;
  localparam int         ACC_W     = 50;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_READ,
    ST_MUL,
    ST_DRAIN,
    ST_WRITE,
    ST_OUT
  } dqbt_state_t;

  typedef struct packed {
    logic       latch;
    logic       rd_en;
    logic [2:0] rd_idx;
    logic       mul_en;
    logic [1:0] mul_q;
    logic [3:0] mul_j;
    logic       wr_en;
    logic [2:0] wr_idx;
    logic       out_ld;
  } dqbt_cmd_t;

  typedef struct packed {
    logic is_point;
    logic bone_ok;
    logic par_root;
  } dqbt_status_t;

  function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
    logic signed [31:0] r;
    if (v > ACC_W'(64'sh7FFF_FFFF)) r = 32'sh7FFF_FFFF;
    else if (v < -ACC_W'(64'sh8000_0000)) r = 32'sh8000_0000;
    else r = v[31:0];
    return r;
  endfunction

  function automatic logic signed [31:0] neg_sat(input logic signed [31:0] v);
    logic signed [31:0] r;
    if (v == 32'sh8000_0000) r = 32'sh7FFF_FFFF;
    else r = -v;
    return r;
  endfunction

  // Operand b index for product term t of component c.
  function automatic logic [1:0] b_index(input logic [1:0] c, input logic [1:0] t);
    logic [1:0] r;
    unique case (c)
      2'd0: r = t;
      2'd1: r = t ^ 2'd1;
      2'd2: r = t ^ 2'd2;
      default: r = t ^ 2'd3;
    endcase
    return r;
  endfunction

  function automatic logic term_neg(input logic [1:0] c, input logic [1:0] t);
    logic r;
    unique case (c)
      2'd0: r = (t != 2'd0);
      2'd1: r = (t == 2'd3);
      2'd2: r = (t == 2'd1);
      default: r = (t == 2'd2);
    endcase
    return r;
  endfunction

endpackage

FILE: sv/dqbt_ctrl.sv
// Sequencing state machine of the dual quaternion bone transform.
module dqbt_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  dqbt_pkg::dqbt_status_t status,
  output logic                  busy,
  output dqbt_pkg::dqbt_cmd_t    cmd
);
  import dqbt_pkg::*;

  dqbt_state_t state_r, state_nxt;
  logic [5:0]  cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    cmd        = '0;
    cmd.rd_idx = cnt_r[2:0];
    cmd.mul_q  = cnt_r[5:4];
    cmd.mul_j  = cnt_r[3:0];
    cmd.wr_idx = cnt_r[2:0];
    busy       = (state_r != ST_IDLE);
    unique case (state_r)
      ST_IDLE: begin
        cmd.latch = start;
        cnt_nxt   = '0;
        if (start) state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        priority if (!status.is_point && !status.bone_ok) state_nxt = ST_IDLE;
        else if (!status.is_point && status.par_root) state_nxt = ST_WRITE;
        else if (status.is_point && !status.bone_ok) state_nxt = ST_OUT;
        else state_nxt = ST_READ;
      end
      ST_READ: begin
        cmd.rd_en = (cnt_r < 6'd8);
        cnt_nxt   = cnt_r + 6'd1;
        if (cnt_r == 6'd8) begin
          cnt_nxt   = '0;
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.mul_en = 1'b1;
        cnt_nxt    = cnt_r + 6'd1;
        if (cnt_r == 6'd47) begin
          cnt_nxt   = '0;
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == 6'd1) begin
          cnt_nxt   = '0;
          state_nxt = status.is_point ? ST_OUT : ST_WRITE;
        end
      end
      ST_WRITE: begin
        cmd.wr_en = 1'b1;
        cnt_nxt   = cnt_r + 6'd1;
        if (cnt_r == 6'd7) begin
          cnt_nxt   = '0;
          state_nxt = ST_IDLE;
        end
      end
      ST_OUT: begin
        cmd.out_ld = 1'b1;
        state_nxt  = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

FILE: sv/dqbt_datapath.sv
// Motor store, shared multiplier and accumulator of the dual quaternion bone transform.
module dqbt_datapath #(
  parameter int MAX_BONES = 8
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  dqbt_pkg::dqbt_cmd_t     cmd,
  output dqbt_pkg::dqbt_status_t  status,
  input  logic                   in_func,
  input  logic [2:0]             in_bone,
  input  logic signed [31:0]     in_rot_w,
  input  logic signed [31:0]     in_rot_x,
  input  logic signed [31:0]     in_rot_y,
  input  logic signed [31:0]     in_rot_z,
  input  logic signed [31:0]     in_dual_w,
  input  logic signed [31:0]     in_dual_x,
  input  logic signed [31:0]     in_dual_y,
  input  logic signed [31:0]     in_dual_z,
  input  logic                   cfg_we,
  input  logic [31:0]            cfg_wdata,
  output logic                   out_strobe,
  output logic signed [31:0]     out_x,
  output logic signed [31:0]     out_y,
  output logic signed [31:0]     out_z
);
  import dqbt_pkg::*;

  logic [31:0]        parent_r;
  logic               func_r;
  logic [2:0]         bone_r;
  logic signed [31:0] lr_r [4];
  logic signed [31:0] ld_r [4];
  logic signed [31:0] p_r [8];
  logic signed [31:0] res_r [3][4];
  logic [31:0]        mem_r [MAX_BONES*8];
  logic [31:0]        rd_data_r;
  logic               rd_vld_r;
  logic [2:0]         rd_idx_r;

  logic signed [63:0] prod_r;
  logic               pv_r, pneg_r, plast_r;
  logic [1:0]         pq_r, pc_r;
  logic signed [ACC_W-1:0] acc_r;

  logic               strobe_r;
  logic signed [31:0] ox_r, oy_r, oz_r;

  logic [3:0]         par;
  logic [2:0]         src;
  logic signed [31:0] cr [4];
  logic signed [31:0] a_vec [4];
  logic signed [31:0] b_vec [4];
  logic signed [31:0] a_sel, b_sel;
  logic signed [47:0] term;
  logic signed [ACC_W-1:0] sterm, sum;
  logic signed [31:0] wdata;
  logic signed [31:0] fin [3];

  assign par = parent_r[{bone_r, 2'b00} +: 4];
  assign status.is_point = func_r;
  assign status.bone_ok  = ({1'b0, bone_r} < 4'(MAX_BONES));
  assign status.par_root = (par == ROOT_MARK) || (par >= 4'(MAX_BONES));
  assign src = func_r ? bone_r : par[2:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      parent_r <= 32'hFFFF_FFFF;
    end else if (cfg_we) begin
      parent_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      func_r   <= in_func;
      bone_r   <= in_bone;
      lr_r[0]  <= in_rot_w;
      lr_r[1]  <= in_rot_x;
      lr_r[2]  <= in_rot_y;
      lr_r[3]  <= in_rot_z;
      ld_r[0]  <= in_dual_w;
      ld_r[1]  <= in_dual_x;
      ld_r[2]  <= in_dual_y;
      ld_r[3]  <= in_dual_z;
    end
  end

  // Motor store: one write and one registered read a cycle.
  always_ff @(posedge clk) begin
    if (cmd.wr_en) mem_r[{bone_r, cmd.wr_idx}] <= wdata;
    rd_data_r <= mem_r[{src, cmd.rd_idx}];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= cmd.rd_en;
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r <= cmd.rd_idx;
    if (rd_vld_r) p_r[rd_idx_r] <= rd_data_r;
  end

  always_comb begin
    cr[0] = p_r[0];
    for (int i = 1; i < 4; i++) cr[i] = neg_sat(p_r[i]);
    for (int i = 0; i < 4; i++) begin
      unique case (cmd.mul_q)
        2'd0: begin
          a_vec[i] = p_r[i];
          b_vec[i] = func_r ? ((i == 0) ? 32'sd0 : lr_r[i]) : lr_r[i];
        end
        2'd1: begin
          a_vec[i] = func_r ? p_r[4+i] : p_r[i];
          b_vec[i] = func_r ? cr[i] : ld_r[i];
        end
        default: begin
          a_vec[i] = func_r ? res_r[0][i] : p_r[4+i];
          b_vec[i] = func_r ? cr[i] : lr_r[i];
        end
      endcase
    end
    a_sel = a_vec[cmd.mul_j[1:0]];
    b_sel = b_vec[b_index(cmd.mul_j[3:2], cmd.mul_j[1:0])];
  end

  // Stage one: product of one term.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r <= 1'b0;
    end else begin
      pv_r <= cmd.mul_en;
    end
  end

  always_ff @(posedge clk) begin
    prod_r  <= 64'(a_sel) * 64'(b_sel);
    pneg_r  <= term_neg(cmd.mul_j[3:2], cmd.mul_j[1:0]);
    plast_r <= (cmd.mul_j[1:0] == 2'd3);
    pq_r    <= cmd.mul_q;
    pc_r    <= cmd.mul_j[3:2];
  end

  // Stage two: floor shift, signed accumulate, saturate on the fourth term.
  assign term  = prod_r[63:16];
  assign sterm = pneg_r ? -ACC_W'(term) : ACC_W'(term);
  assign sum   = acc_r + sterm;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else if (pv_r) begin
      acc_r <= plast_r ? '0 : sum;
    end
  end

  always_ff @(posedge clk) begin
    if (pv_r && plast_r) res_r[pq_r][pc_r] <= sat32(sum);
  end

  always_comb begin
    if (status.par_root) begin
      wdata = cmd.wr_idx[2] ? ld_r[cmd.wr_idx[1:0]] : lr_r[cmd.wr_idx[1:0]];
    end else if (cmd.wr_idx[2]) begin
      wdata = sat32(ACC_W'(res_r[1][cmd.wr_idx[1:0]]) + ACC_W'(res_r[2][cmd.wr_idx[1:0]]));
    end else begin
      wdata = res_r[0][cmd.wr_idx[1:0]];
    end
    for (int i = 0; i < 3; i++) begin
      fin[i] = sat32(ACC_W'(res_r[2][i+1]) + (ACC_W'(res_r[1][i+1]) <<< 1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= cmd.out_ld;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_ld) begin
      ox_r <= status.bone_ok ? fin[0] : 32'sd0;
      oy_r <= status.bone_ok ? fin[1] : 32'sd0;
      oz_r <= status.bone_ok ? fin[2] : 32'sd0;
    end
  end

  assign out_strobe = strobe_r;
  assign out_x      = ox_r;
  assign out_y      = oy_r;
  assign out_z      = oz_r;

endmodule

FILE: sv/dual_quaternion_bone_transform.sv
// Top level of the dual quaternion bone transform: controller plus datapath.
//
//   channel   ports                              handshake
//   request   start, in_func .. in_dual_z        start && !busy
//   result    out_strobe, out_x, out_y, out_z    one-cycle strobe
//   config    cfg_we, cfg_wdata                  cfg_we
//
// A child motor load and a point each make 48 passes through the single shared 32x32
// multiplier after an 8-word read of the motor store (one write, one read port); child
// and root motor loads write 8 words. A point on a bone out of range returns zeros.
// Reset is synchronous and active low; all bones start as roots, motors undefined.
// The result strobe is high for one cycle after a point request completes; no stall is possible.
module dual_quaternion_bone_transform #(
  parameter int MAX_BONES = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic               in_func,
  input  logic [2:0]         in_bone,
  input  logic signed [31:0] in_rot_w,
  input  logic signed [31:0] in_rot_x,
  input  logic signed [31:0] in_rot_y,
  input  logic signed [31:0] in_rot_z,
  input  logic signed [31:0] in_dual_w,
  input  logic signed [31:0] in_dual_x,
  input  logic signed [31:0] in_dual_y,
  input  logic signed [31:0] in_dual_z,
  input  logic               cfg_we,
  input  logic [31:0]        cfg_wdata,
  output logic               out_strobe,
  output logic signed [31:0] out_x,
  output logic signed [31:0] out_y,
  output logic signed [31:0] out_z
);
  import dqbt_pkg::*;

  dqbt_cmd_t    cmd;
  dqbt_status_t status;

  dqbt_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .status (status),
    .busy   (busy),
    .cmd    (cmd)
  );

  dqbt_datapath #(.MAX_BONES(MAX_BONES)) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .status     (status),
    .in_func    (in_func),
    .in_bone    (in_bone),
    .in_rot_w   (in_rot_w),
    .in_rot_x   (in_rot_x),
    .in_rot_y   (in_rot_y),
    .in_rot_z   (in_rot_z),
    .in_dual_w  (in_dual_w),
    .in_dual_x  (in_dual_x),
    .in_dual_y  (in_dual_y),
    .in_dual_z  (in_dual_z),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .out_strobe (out_strobe),
    .out_x      (out_x),
    .out_y      (out_y),
    .out_z      (out_z)
  );

  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !busy) else $error("result strobe while a request is in flight");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("accepted request did not raise busy");

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.wr_en && (cmd.mul_en || cmd.rd_en))) else $error("store write overlaps compute");

  a_out_follows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_ld |=> out_strobe) else $error("output load did not strobe");

endmodule
